@@ src/sprht_pkg.sv @@
// ----------------------------------------------------------------------------
// sprht_pkg
// Shared types, codes and helpers for the sprite rectangle pixel hit test.
// ----------------------------------------------------------------------------
package sprht_pkg;

  // Default image store size in bytes
  localparam int STORE_BYTES_DEF = 4096;

  // Port widths
  localparam int IN_TDATA_W  = 120;  // 116 bits of fields, padded to 15 bytes
  localparam int OUT_TDATA_W = 8;    // hit, padded to one byte
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  // Wide unsigned width for store addresses (row base plus byte offset)
  localparam int WIDE_W = 24;
  // Signed width for screen-space clip arithmetic
  localparam int CLIP_W = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_ORDER    = 3'd4;

  // Pixel depth codes (the unused code reads as one bit)
  localparam logic [1:0] DEPTH_1BIT = 2'd0;
  localparam logic [1:0] DEPTH_4BIT = 2'd1;
  localparam logic [1:0] DEPTH_8BIT = 2'd2;

  // Request kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic byte_wr;
    logic query_ld;
    logic clip1;
    logic clip2;
    logic init_scan;
    logic issue;
    logic res_set;
    logic out_load;
  } sprht_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic last_issue;
    logic pix_hit;
    logic out_free;
  } sprht_stat_t;

  // Byte offset of pixel column x within its row
  function automatic logic [9:0] px_byte(input logic [9:0] x, input logic [1:0] depth);
    logic [9:0] r;
    begin
      unique case (depth)
        DEPTH_8BIT: r = x;
        DEPTH_4BIT: r = {1'b0, x[9:1]};
        default:    r = {3'b000, x[9:3]};
      endcase
      return r;
    end
  endfunction

  // Nonzero test of the pixel picked from a byte by the low column bits
  function automatic logic px_nonzero(input logic [7:0] b, input logic [2:0] sel,
                                      input logic [1:0] depth);
    logic r;
    begin
      unique case (depth)
        DEPTH_8BIT: r = (b != 8'd0);
        DEPTH_4BIT: r = sel[0] ? (b[3:0] != 4'd0) : (b[7:4] != 4'd0);
        default:    r = b[3'd7 - sel];
      endcase
      return r;
    end
  endfunction

endpackage

@@ src/sprht_ctrl.sv @@
// ----------------------------------------------------------------------------
// sprht_ctrl
// Sequencer: takes requests, walks a query through clip, scan and result.
// ----------------------------------------------------------------------------
module sprht_ctrl
  import sprht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tuser,
  input  sprht_stat_t st,
  output sprht_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLIP1 = 3'd1;
  localparam logic [2:0] ST_CLIP2 = 3'd2;
  localparam logic [2:0] ST_CLIP3 = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        // take nothing while reset is held
        if (rst_n) begin
          cmd.in_ready = 1'b1;
          if (in_tvalid) begin
            if (in_tuser == OP_QUERY) begin
              cmd.query_ld = 1'b1;
              state_nxt    = ST_CLIP1;
            end else begin
              cmd.byte_wr = 1'b1;
            end
          end
        end
      end
      ST_CLIP1: begin
        cmd.clip1 = 1'b1;
        state_nxt = ST_CLIP2;
      end
      ST_CLIP2: begin
        cmd.clip2 = 1'b1;
        state_nxt = ST_CLIP3;
      end
      ST_CLIP3: begin
        if (st.empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.init_scan = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.pix_hit) begin
          cmd.res_set = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.issue = 1'b1;
          if (st.last_issue) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd.res_set = st.pix_hit;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_query_starts_clip: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.query_ld |=> cmd.clip1)
    else $error("query accepted without clip step");

  a_query_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.query_ld |=> !cmd.in_ready)
    else $error("new request taken while a query is open");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a pending result");

endmodule

@@ src/sprht_dpath.sv @@
// ----------------------------------------------------------------------------
// sprht_dpath
// Config registers, image store, clip arithmetic, scan counters and result.
// ----------------------------------------------------------------------------
module sprht_dpath
  import sprht_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  sprht_cmd_t             cmd,
  output sprht_stat_t            st,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int ADDR_W = $clog2(STORE_BYTES);

  // Config registers
  logic [9:0]  img_w_r;
  logic [9:0]  img_h_r;
  logic [11:0] stride_r;
  logic [1:0]  depth_r;
  logic        rows_flipped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r        <= '0;
      img_h_r        <= '0;
      stride_r       <= '0;
      depth_r        <= DEPTH_8BIT;
      rows_flipped_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r        <= cfg_data[9:0];
        CFG_IMAGE_HEIGHT: img_h_r        <= cfg_data[9:0];
        CFG_ROW_STRIDE:   stride_r       <= cfg_data[11:0];
        CFG_PIXEL_DEPTH:  depth_r        <= cfg_data[1:0];
        CFG_ROW_ORDER:    rows_flipped_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request fields
  logic [11:0]        f_byte_index;
  logic [7:0]         f_byte_value;
  logic signed [15:0] f_left, f_top, f_rx, f_ry, f_rw, f_rh;

  assign f_byte_index = in_tdata[11:0];
  assign f_byte_value = in_tdata[19:12];
  assign f_left       = $signed(in_tdata[35:20]);
  assign f_top        = $signed(in_tdata[51:36]);
  assign f_rx         = $signed(in_tdata[67:52]);
  assign f_ry         = $signed(in_tdata[83:68]);
  assign f_rw         = $signed(in_tdata[99:84]);
  assign f_rh         = $signed(in_tdata[115:100]);

  // Image store
  logic [7:0]        mem [STORE_BYTES];
  logic [WIDE_W-1:0] wr_wide;
  logic              wr_ok;

  assign wr_wide = WIDE_W'(f_byte_index);
  assign wr_ok   = (wr_wide < WIDE_W'(STORE_BYTES));

  always_ff @(posedge clk) begin
    if (cmd.byte_wr && wr_ok) begin
      mem[wr_wide[ADDR_W-1:0]] <= f_byte_value;
    end
  end

  // Query capture
  logic signed [CLIP_W-1:0] left_r, top_r, rx_r, ry_r, rw_r, rh_r;

  always_ff @(posedge clk) begin
    if (cmd.query_ld) begin
      left_r <= CLIP_W'(f_left);
      top_r  <= CLIP_W'(f_top);
      rx_r   <= CLIP_W'(f_rx);
      ry_r   <= CLIP_W'(f_ry);
      rw_r   <= CLIP_W'(f_rw);
      rh_r   <= CLIP_W'(f_rh);
    end
  end

  // Clip step one: corners of the overlap
  logic signed [CLIP_W-1:0] rect_r_edge, rect_b_edge, img_r_edge, img_b_edge;
  logic signed [CLIP_W-1:0] fx_r, fy_r, lx_r, ly_r;
  logic                     nonpos_r;

  assign rect_r_edge = rx_r + rw_r;
  assign rect_b_edge = ry_r + rh_r;
  assign img_r_edge  = left_r + $signed({8'd0, img_w_r});
  assign img_b_edge  = top_r + $signed({8'd0, img_h_r});

  always_ff @(posedge clk) begin
    if (cmd.clip1) begin
      fx_r     <= (rx_r > left_r) ? rx_r : left_r;
      fy_r     <= (ry_r > top_r) ? ry_r : top_r;
      lx_r     <= (img_r_edge < rect_r_edge) ? img_r_edge : rect_r_edge;
      ly_r     <= (img_b_edge < rect_b_edge) ? img_b_edge : rect_b_edge;
      nonpos_r <= (rw_r <= 0) || (rh_r <= 0);
    end
  end

  // Clip step two: image-space bounds
  logic signed [CLIP_W-1:0] px0_d, pxe_d, py0_d, pye_d;
  logic [9:0] px0_r, pxe_r, py0_r, pye_r;
  logic       empty_r;

  assign px0_d = fx_r - left_r;
  assign pxe_d = lx_r - left_r;
  assign py0_d = fy_r - top_r;
  assign pye_d = ly_r - top_r;

  always_ff @(posedge clk) begin
    if (cmd.clip2) begin
      empty_r <= nonpos_r || (fx_r >= lx_r) || (fy_r >= ly_r);
      px0_r   <= px0_d[9:0];
      pxe_r   <= pxe_d[9:0];
      py0_r   <= py0_d[9:0];
      pye_r   <= pye_d[9:0];
    end
  end

  // Scan counters and row base
  logic [9:0]        x_r, y_r;
  logic [9:0]        x_nxt, y_nxt;
  logic [WIDE_W-1:0] row_base_r, row_base_nxt;
  logic [9:0]        sy0;
  logic [10:0]       x_inc, y_inc;
  logic              col_last, row_last;

  assign sy0      = rows_flipped_r ? (img_h_r - 10'd1 - py0_r) : py0_r;
  assign x_inc    = {1'b0, x_r} + 11'd1;
  assign y_inc    = {1'b0, y_r} + 11'd1;
  assign col_last = (x_inc == {1'b0, pxe_r});
  assign row_last = (y_inc == {1'b0, pye_r});

  always_comb begin
    x_nxt        = x_r;
    y_nxt        = y_r;
    row_base_nxt = row_base_r;
    if (cmd.init_scan) begin
      x_nxt        = px0_r;
      y_nxt        = py0_r;
      row_base_nxt = WIDE_W'(sy0) * WIDE_W'(stride_r);
    end else if (cmd.issue) begin
      if (col_last) begin
        x_nxt        = px0_r;
        y_nxt        = y_inc[9:0];
        row_base_nxt = rows_flipped_r ? (row_base_r - WIDE_W'(stride_r))
                                      : (row_base_r + WIDE_W'(stride_r));
      end else begin
        x_nxt = x_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
    row_base_r <= row_base_nxt;
  end

  // Pixel read: address, registered store read, then test
  logic [WIDE_W-1:0] rd_addr;
  logic [7:0]        rd_data_r;
  logic [2:0]        rd_sel_r;
  logic              rd_oob_r;
  logic              rd_valid_r;

  assign rd_addr = row_base_r + WIDE_W'(px_byte(x_r, depth_r));

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr[ADDR_W-1:0]];
      rd_sel_r  <= x_r[2:0];
      rd_oob_r  <= (rd_addr >= WIDE_W'(STORE_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.issue;
    end
  end

  // Result and output register
  logic res_hit_r;
  logic out_valid_r;
  logic out_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.query_ld) begin
      res_hit_r <= 1'b0;
    end else if (cmd.res_set) begin
      res_hit_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_hit_r <= res_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_hit_r};

  assign st.empty      = empty_r;
  assign st.last_issue = col_last && row_last;
  assign st.pix_hit    = rd_valid_r && !rd_oob_r && px_nonzero(rd_data_r, rd_sel_r, depth_r);
  assign st.out_free   = !out_valid_r || out_tready;

  a_issue_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (x_r < pxe_r) && (y_r < pye_r))
    else $error("pixel read outside the clipped overlap");

  a_hit_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    st.pix_hit |-> $past(cmd.issue))
    else $error("hit seen without a pixel read");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

@@ src/sprite_rect_pixel_hit_test_core.sv @@
// ----------------------------------------------------------------------------
// sprite_rect_pixel_hit_test_core
// Pixel-accurate hit test of a screen rectangle against a stored sprite.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | in        | in_tvalid/tready   | tuser: op; tdata: byte write or
//          |           |                    | query fields
//  out_    | out       | out_tvalid/tready  | tdata: hit (one per query)
//  cfg_    | in        | cfg_we, no wait    | cfg_index, cfg_data
//
// Sequence: a byte write is stored as it is accepted. A query is accepted,
//   steps through clip states ST_CLIP1, ST_CLIP2 and ST_CLIP3, then issues
//   one store read per overlap pixel scanned (stopping at the first set
//   pixel), tests the last store read in ST_DRAIN and loads the result in
//   ST_DONE; an empty overlap goes from ST_CLIP3 straight to ST_DONE.
// Reset: synchronous, active low; clears the sequencer, the result slot and
//   the config registers, and takes no request while held. The image store
//   holds garbage until written.
// Stalls: a finished result waits in the output register; new requests are
//   taken while it waits, and the next query result holds until it drains.
//
module sprite_rect_pixel_hit_test_core
  import sprht_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [11:0] byte_index, [19:12] byte_value, [35:20] image_left,
  // [51:36] image_top, [67:52] rect_x, [83:68] rect_y,
  // [99:84] rect_width, [115:100] rect_height, [119:116] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,   // [0] op: write byte or query
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] hit, [7:1] zero
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  sprht_cmd_t  cmd;
  sprht_stat_t st;

  // Sequencer: owns the request handshake and steps each query
  sprht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: store, clip math, scan counters, result slot
  sprht_dpath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Take requests only when the sequencer is idle
  assign in_tready = cmd.in_ready;

endmodule
